// ----- hw/rtl/crlf_pkg.sv -----
package crlf_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 7;
  localparam int LEN_W  = 7;
  localparam int FUNC_W = 2;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0a;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_t;

  typedef struct packed {
    logic             line_done;
    logic             line_complete;
    logic             cr_seen;
    logic [LEN_W-1:0] line_length;
    logic             rd_ok;
  } out_meta_t;

  typedef struct packed {
    out_meta_t         meta;
    logic [BYTE_W-1:0] rdata;
  } q_entry_t;

endpackage

// ----- hw/rtl/crlf_ram.sv -----
module crlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/crlf_front.sv -----
module crlf_front #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [crlf_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [crlf_pkg::FUNC_W-1:0]  s_tuser,
  input  logic [crlf_pkg::Q_CW-1:0]    q_level,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [crlf_pkg::BYTE_W-1:0]  mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  output logic                         s1_valid,
  output crlf_pkg::out_meta_t          s1_meta
);

  import crlf_pkg::*;

  logic              complete, complete_next;
  logic              cr, cr_next;
  logic [AW-1:0]     count, count_next;
  logic              pend_valid, pend_valid_next;
  logic [AW-1:0]     pend_idx;
  logic              accept;
  logic [BYTE_W-1:0] rx_byte;
  logic [IDX_W-1:0]  read_index;
  logic [AW:0]       count_plus;
  logic              wr_byte;
  logic              new_pend;
  logic              done;
  logic              is_read;
  logic              in_range;
  logic [AW+IDX_W-1:0] idx_wide;
  logic [AW+LEN_W-1:0] len_wide;

  assign accept     = s_tvalid && s_tready;
  assign rx_byte    = s_tdata[BYTE_W-1:0];
  assign read_index = s_tdata[BYTE_W+IDX_W-1:BYTE_W];
  assign s_tready   = ({1'b0, q_level} + (Q_CW+1)'(s1_valid)) < (Q_CW+1)'(Q_DEPTH);
  assign count_plus = (AW+1)'(count) + (AW+1)'(1);
  assign idx_wide   = {AW'(0), read_index};
  assign mem_raddr  = idx_wide[AW-1:0];
  assign in_range   = int'(read_index) < DEPTH;
  assign len_wide   = {LEN_W'(0), count_next};

  always_comb begin
    complete_next = complete;
    cr_next       = cr;
    count_next    = count;
    done          = 1'b0;
    wr_byte       = 1'b0;
    new_pend      = 1'b0;
    is_read       = 1'b0;
    if (accept) begin
      case (func_t'(s_tuser))
        FUNC_BYTE: begin
          if (!complete) begin
            if (cr) begin
              if (rx_byte != BYTE_LF) begin
                count_next    = '0;
                cr_next       = 1'b0;
                complete_next = 1'b0;
              end else begin
                complete_next = 1'b1;
                done          = 1'b1;
              end
            end else if (rx_byte == BYTE_CR) begin
              cr_next = 1'b1;
            end else begin
              wr_byte = 1'b1;
              if (count_plus == (AW+1)'(DEPTH)) begin
                count_next = '0;
              end else begin
                count_next = count_plus[AW-1:0];
                new_pend   = 1'b1;
              end
            end
          end
        end
        FUNC_READ: begin
          is_read = 1'b1;
        end
        FUNC_RELEASE: begin
          complete_next = 1'b0;
          cr_next       = 1'b0;
          count_next    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // data write wins the port; otherwise flush the pending terminator
  always_comb begin
    if (wr_byte) begin
      mem_we    = 1'b1;
      mem_waddr = count;
      mem_wdata = rx_byte;
    end else begin
      mem_we    = pend_valid;
      mem_waddr = pend_idx;
      mem_wdata = '0;
    end
    pend_valid_next = wr_byte ? new_pend : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      complete   <= 1'b0;
      cr         <= 1'b0;
      count      <= '0;
      pend_valid <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      complete   <= complete_next;
      cr         <= cr_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      s1_valid   <= accept;
    end
    if (wr_byte) begin
      pend_idx <= count_next;
    end
    if (accept) begin
      s1_meta.line_done     <= done;
      s1_meta.line_complete <= complete_next;
      s1_meta.cr_seen       <= cr_next;
      s1_meta.line_length   <= len_wide[LEN_W-1:0];
      s1_meta.rd_ok         <= is_read && in_range &&
                               !(pend_valid && mem_raddr == pend_idx);
    end
  end

endmodule

// ----- hw/rtl/crlf_queue.sv -----
module crlf_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  crlf_pkg::q_entry_t         push_entry,
  input  logic                       pop,
  output logic                       head_valid,
  output crlf_pkg::q_entry_t         head,
  output logic [crlf_pkg::Q_CW-1:0]  level
);

  import crlf_pkg::*;

  q_entry_t         slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;
  logic             do_pop;

  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign level      = count;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + Q_CW'(1);
        2'b01:   count <= count - Q_CW'(1);
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/crlf_back.sv -----
module crlf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  crlf_pkg::q_entry_t             head,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [crlf_pkg::M_TDATA_W-1:0] m_tdata
);

  import crlf_pkg::*;

  localparam int PAD_W = M_TDATA_W - (3 + LEN_W + BYTE_W);

  logic              load;
  logic [BYTE_W-1:0] read_data;

  assign load      = head_valid && (!m_tvalid || m_tready);
  assign pop       = load;
  assign read_data = head.meta.rd_ok ? head.rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      m_tdata <= {PAD_W'(0), read_data, head.meta.line_length, head.meta.cr_seen,
                  head.meta.line_complete, head.meta.line_done};
    end
  end

endmodule

// ----- hw/rtl/crlf_line_receiver.sv -----
// channel   dir  tdata (lowest bit up)                                   tuser
// s_axis    in   rx_byte[7:0] read_index[14:8] zero[15]                  func[1:0]
// m_axis    out  line_done[0] line_complete[1] cr_seen[2]                -
//                line_length[9:3] read_data[17:10] zero[23:18]
//
// One beat per cycle in while s_tready is high.
// Path: state update and buffer access at accept, registered buffer read, queue, output reg.
// Reset (synchronous): status flags and count clear; buffer contents stay undefined until written.
// s_tready drops only while m_axis stalls and the 4-entry result queue, together with
// the beat on its way into it, is full.
module crlf_line_receiver #(
  parameter int DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [crlf_pkg::S_TDATA_W-1:0] s_tdata,   // rx_byte, read_index
  input  logic [crlf_pkg::FUNC_W-1:0]    s_tuser,   // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [crlf_pkg::M_TDATA_W-1:0] m_tdata    // line_done, line_complete, cr_seen,
                                                    // line_length, read_data
);

  import crlf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  logic              s1_valid;
  out_meta_t         s1_meta;
  q_entry_t          push_entry;
  logic [Q_CW-1:0]   q_level;
  logic              head_valid;
  q_entry_t          head;
  logic              pop;

  crlf_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_level   (q_level),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .s1_valid  (s1_valid),
    .s1_meta   (s1_meta)
  );

  crlf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign push_entry.meta  = s1_meta;
  assign push_entry.rdata = mem_rdata;

  crlf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (q_level)
  );

  crlf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import crlf_pkg::*;

  localparam int LINE_DEPTH  = 128;
  localparam int N_ITEMS     = 1300;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_PRINTS  = 20;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic              done;
    logic              complete;
    logic              cr;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] rdata;
  } line_status_t;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [BYTE_W-1:0] b;
    logic [IDX_W-1:0]  idx;
    logic              fixed;
    line_status_t      st;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  logic         beat_fixed = 1'b0;
  line_status_t beat_fixed_status = '0;

  bit              held_line;
  bit              cr_pending;
  int unsigned     char_cnt;
  logic [7:0]      line_mem [LINE_DEPTH];
  int              filled_idx[$];
  bit              mem_valid [LINE_DEPTH];
  line_status_t    pending_status[$];
  dir_row_t        dir_rows[$];
  bit              gaps_on = 1'b1;

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int n_beats = 0;
  int n_results = 0;
  int n_lines = 0;
  int n_discards = 0;
  int n_wraps = 0;
  int n_reads = 0;

  crlf_line_receiver #(
    .DEPTH(LINE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_status.size());
      $display("crlf_line_receiver test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0h expected %0h", n_results, what, got, want);
  endtask

  function automatic void store_char(input int unsigned pos, input logic [7:0] v);
    line_mem[pos] = v;
    if (!mem_valid[pos]) begin
      mem_valid[pos] = 1'b1;
      filled_idx.push_back(pos);
    end
  endfunction

  function automatic line_status_t line_model_step(input logic [FUNC_W-1:0] fn,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [IDX_W-1:0] idx);
    line_status_t r;
    r = '0;
    case (fn)
      FUNC_BYTE: begin
        if (held_line) begin
        end else if (cr_pending) begin
          if (b != BYTE_LF) begin
            char_cnt = 0;
            cr_pending = 1'b0;
            held_line = 1'b0;
            n_discards++;
          end else begin
            held_line = 1'b1;
            r.done = 1'b1;
            n_lines++;
          end
        end else if (b == BYTE_CR) begin
          cr_pending = 1'b1;
        end else begin
          store_char(char_cnt, b);
          char_cnt++;
          if (char_cnt < LINE_DEPTH)
            store_char(char_cnt, 8'h00);
          else begin
            char_cnt = 0;
            n_wraps++;
          end
        end
      end
      FUNC_READ: begin
        if (idx < LINE_DEPTH)
          r.rdata = line_mem[idx];
        n_reads++;
      end
      FUNC_RELEASE: begin
        held_line = 1'b0;
        cr_pending = 1'b0;
        char_cnt = 0;
      end
      default: ;
    endcase
    r.complete = held_line;
    r.cr = cr_pending;
    r.len = char_cnt[LEN_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    line_status_t want;
    line_status_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = line_model_step(s_tuser, s_tdata[7:0], s_tdata[14:8]);
        n_beats++;
        pending_status.push_back(beat_fixed ? beat_fixed_status : want);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[9:3], m_tdata[17:10]};
        n_results++;
        if (pending_status.size() == 0) begin
          report_mismatch("result with nothing pending", m_tdata, 0);
        end else begin
          want = pending_status.pop_front();
          if (got.done !== want.done)
            report_mismatch("line_done", got.done, want.done);
          if (got.complete !== want.complete)
            report_mismatch("line_complete", got.complete, want.complete);
          if (got.cr !== want.cr)
            report_mismatch("cr_seen", got.cr, want.cr);
          if (got.len !== want.len)
            report_mismatch("line_length", got.len, want.len);
          if (got.rdata !== want.rdata)
            report_mismatch("read_data", got.rdata, want.rdata);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int st;
    wait (!rst);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      st = pick_gap();
      if (st > 0) begin
        m_tready <= 1'b0;
        repeat (st) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [BYTE_W-1:0] b,
                           input logic [IDX_W-1:0] idx, input logic fixed,
                           input line_status_t fixed_st);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {1'b0, idx, b};
    beat_fixed <= fixed;
    beat_fixed_status <= fixed_st;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic put_char(input logic [BYTE_W-1:0] b);
    send_beat(FUNC_BYTE, b, IDX_W'($urandom), 1'b0, '0);
  endtask

  task automatic put_read();
    if (filled_idx.size() == 0)
      send_beat(FUNC_UNUSED, BYTE_W'($urandom), IDX_W'($urandom), 1'b0, '0);
    else
      send_beat(FUNC_READ, BYTE_W'($urandom),
                IDX_W'(filled_idx[$urandom_range(0, filled_idx.size() - 1)]), 1'b0, '0);
  endtask

  task automatic put_text_char();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == BYTE_CR);
    put_char(b);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] fn, input logic [BYTE_W-1:0] b,
                         input logic [IDX_W-1:0] idx, input logic fixed, input logic d,
                         input logic c, input logic cr, input logic [LEN_W-1:0] len,
                         input logic [BYTE_W-1:0] rd);
    dir_row_t row;
    row.fn = fn;
    row.b = b;
    row.idx = idx;
    row.fixed = fixed;
    row.st = '{d, c, cr, len, rd};
    dir_rows.push_back(row);
  endtask

  initial begin
    int kind;
    int len;
    int n;
    bit first_long;
    logic [BYTE_W-1:0] b;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_row(FUNC_UNUSED,  8'ha5,   7'h7f, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_RELEASE, 8'h5a,   7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    8'h00,   7'h7f, 1'b1, 1'b0, 1'b0, 1'b0, 7'd1, 8'h00);
    add_row(FUNC_READ,    8'hff,   7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 7'd1, 8'h00);
    add_row(FUNC_BYTE,    8'hff,   7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 7'd2, 8'h00);
    add_row(FUNC_READ,    8'h00,   7'h01, 1'b1, 1'b0, 1'b0, 1'b0, 7'd2, 8'hff);
    add_row(FUNC_READ,    8'h00,   7'h02, 1'b1, 1'b0, 1'b0, 1'b0, 7'd2, 8'h00);
    add_row(FUNC_BYTE,    BYTE_CR, 7'h00, 1'b1, 1'b0, 1'b0, 1'b1, 7'd2, 8'h00);
    add_row(FUNC_BYTE,    BYTE_LF, 7'h00, 1'b1, 1'b1, 1'b1, 1'b1, 7'd2, 8'h00);
    add_row(FUNC_BYTE,    8'h41,   7'h00, 1'b1, 1'b0, 1'b1, 1'b1, 7'd2, 8'h00);
    add_row(FUNC_BYTE,    BYTE_CR, 7'h00, 1'b1, 1'b0, 1'b1, 1'b1, 7'd2, 8'h00);
    add_row(FUNC_READ,    8'h00,   7'h01, 1'b1, 1'b0, 1'b1, 1'b1, 7'd2, 8'hff);
    add_row(FUNC_UNUSED,  8'hff,   7'h7f, 1'b1, 1'b0, 1'b1, 1'b1, 7'd2, 8'h00);
    add_row(FUNC_RELEASE, 8'h00,   7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    8'h55,   7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 7'd1, 8'h00);
    add_row(FUNC_BYTE,    BYTE_CR, 7'h00, 1'b1, 1'b0, 1'b0, 1'b1, 7'd1, 8'h00);
    add_row(FUNC_BYTE,    BYTE_CR, 7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    BYTE_LF, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    BYTE_CR, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    8'h00,   7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_READ,    8'h00,   7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    8'h7e,   7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    BYTE_CR, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_BYTE,    BYTE_LF, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);
    add_row(FUNC_RELEASE, 8'h00,   7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'h00);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].fn, dir_rows[i].b, dir_rows[i].idx, dir_rows[i].fixed,
                dir_rows[i].st);
    drain_results();

    first_long = 1'b1;
    while (items_sent < N_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (first_long || kind < 70) begin
        if (first_long || $urandom_range(0, 11) == 0)
          len = $urandom_range(100, 140);
        else
          len = $urandom_range(0, 20);
        first_long = 1'b0;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0)
            put_read();
          put_text_char();
        end
        put_char(BYTE_CR);
        put_char(BYTE_LF);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 2))
            0: put_char(BYTE_W'($urandom));
            1: put_read();
            default: send_beat(FUNC_UNUSED, BYTE_W'($urandom), IDX_W'($urandom), 1'b0, '0);
          endcase
        end
        send_beat(FUNC_RELEASE, BYTE_W'($urandom), IDX_W'($urandom), 1'b0, '0);
      end else if (kind < 85) begin
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++)
          put_text_char();
        put_char(BYTE_CR);
        do b = BYTE_W'($urandom); while (b == BYTE_LF);
        put_char(b);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: put_char(BYTE_CR);
            1: put_char(BYTE_LF);
            2: put_char(BYTE_W'($urandom));
            3: put_read();
            4: send_beat(FUNC_RELEASE, BYTE_W'($urandom), IDX_W'($urandom), 1'b0, '0);
            default: send_beat(FUNC_UNUSED, BYTE_W'($urandom), IDX_W'($urandom), 1'b0, '0);
          endcase
        end
      end
      if ($urandom_range(0, 19) == 0)
        drain_results();
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d beats, checked %0d results in %0d cycles", n_beats, n_results, cycles);
    $display("lines closed %0d, discarded after CR %0d, full-depth wraps %0d, reads %0d",
             n_lines, n_discards, n_wraps, n_reads);
    if (errors == 0) begin
      $display("crlf_line_receiver test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("crlf_line_receiver test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/crlf_pkg.sv
hw/rtl/crlf_ram.sv
hw/rtl/crlf_front.sv
hw/rtl/crlf_queue.sv
hw/rtl/crlf_back.sv
hw/rtl/crlf_line_receiver.sv
tb/testbench.sv
